// ===== hdl/stop_and_wait_arq_sender_macros.svh =====
// Assertion helpers shared by the sender modules.
// Every check samples on aclk and is off while aresetn is low.
`ifndef STOP_AND_WAIT_ARQ_SENDER_MACROS_SVH
`define STOP_AND_WAIT_ARQ_SENDER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SAW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition never holds.
`define SAW_NEVER(lbl, expr, msg) \
    `SAW_ASSERT(lbl, !(expr), msg)

`endif

// ===== hdl/sawarq_pkg.sv =====
package sawarq_pkg;

    // Default payload length of one packet in bytes
    localparam int PACKET_BYTES_DEF = 32;

    // Frame layout: source id copies, then packet number copies, then payload
    localparam int ID_COPIES = 3;
    localparam int HDR_BYTES = 6;

    // Depth of the frame command queue between front and back
    localparam int CMD_QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ID = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_ID = 1'b1;

    // Item kinds carried in s_tuser
    localparam logic ITEM_ACK  = 1'b0;
    localparam logic ITEM_DATA = 1'b1;

    // Packet number constants
    localparam logic [7:0] PNUM_FIRST  = 8'd1;
    localparam logic [7:0] PNUM_MAX    = 8'd255;
    localparam logic [7:0] BEACON_BYTE = 8'h00;

    typedef enum logic {
        MODE_RECEIVE = 1'b0,
        MODE_LOAD    = 1'b1
    } mode_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    // Two or more of three copies agree
    function automatic logic vote2(input logic a, input logic b, input logic c);
        return (a & b) | (a & c) | (b & c);
    endfunction

endpackage

// ===== hdl/sawarq_front.sv =====
module sawarq_front
    import sawarq_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_wdata,
    // input item
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   req_type,
    input  logic [7:0]             ack_dest_0,
    input  logic [7:0]             ack_dest_1,
    input  logic [7:0]             ack_dest_2,
    input  logic [7:0]             ack_num_0,
    input  logic [7:0]             ack_num_1,
    input  logic [7:0]             ack_num_2,
    input  logic [7:0]             data_byte,
    // back side status
    input  logic                   q_full,
    input  logic                   store_busy,
    // frame command push
    output logic                   q_push,
    output logic [7:0]             q_pnum,
    // packet store write
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output logic [7:0]             wr_data,
    output logic [7:0]             node_id
);

    mode_t         mode_reg, mode_next;
    logic [7:0]    pnum_reg, pnum_next;
    logic          ack_seen_reg, ack_seen_next;
    logic          beacon_seen_reg, beacon_seen_next;
    logic [AW-1:0] load_idx_reg, load_idx_next;
    logic [7:0]    node_id_reg;
    logic [7:0]    dest_id_reg;

    logic          accept;
    logic          dest_ok;
    logic          next_vote;
    logic          prev_vote;
    logic          beacon_vote;
    logic [7:0]    prev_num;
    logic          take_data;
    logic          take_ack;
    logic          store_full;
    logic          resend;

    // Classify the offered item
    always_comb begin
        prev_num    = pnum_reg - 8'd1;
        dest_ok     = (ack_dest_0 == dest_id_reg) && (ack_dest_1 == dest_id_reg)
                      && (ack_dest_2 == dest_id_reg);
        next_vote   = vote2(ack_num_0 == pnum_reg, ack_num_1 == pnum_reg,
                            ack_num_2 == pnum_reg);
        prev_vote   = vote2(ack_num_0 == prev_num, ack_num_1 == prev_num,
                            ack_num_2 == prev_num);
        beacon_vote = vote2(ack_num_0 == BEACON_BYTE, ack_num_1 == BEACON_BYTE,
                            ack_num_2 == BEACON_BYTE);
        s_tready    = !q_full && !((req_type == ITEM_DATA) && (mode_reg == MODE_LOAD)
                                   && store_busy);
        accept      = s_tvalid && s_tready;
        take_data   = accept && (req_type == ITEM_DATA) && (mode_reg == MODE_LOAD);
        take_ack    = accept && (req_type == ITEM_ACK) && (mode_reg == MODE_RECEIVE)
                      && dest_ok;
        store_full  = load_idx_reg == AW'(PACKET_BYTES - 1);
        resend      = take_ack && !next_vote
                      && (ack_seen_reg ? prev_vote : (beacon_vote && beacon_seen_reg));
    end

    // Next state of the protocol
    always_comb begin
        mode_next        = mode_reg;
        pnum_next        = pnum_reg;
        ack_seen_next    = ack_seen_reg;
        beacon_seen_next = beacon_seen_reg;
        load_idx_next    = load_idx_reg;
        if (take_data) begin
            if (store_full) begin
                load_idx_next = '0;
                mode_next     = MODE_RECEIVE;
            end else begin
                load_idx_next = load_idx_reg + AW'(1);
            end
        end else if (take_ack) begin
            if (next_vote) begin
                ack_seen_next = 1'b1;
                pnum_next     = (pnum_reg == PNUM_MAX) ? PNUM_FIRST : pnum_reg + 8'd1;
                mode_next     = MODE_LOAD;
                load_idx_next = '0;
            end else if (!ack_seen_reg && beacon_vote && !beacon_seen_reg) begin
                beacon_seen_next = 1'b1;
                mode_next        = MODE_LOAD;
                load_idx_next    = '0;
            end
        end
    end

    // Drive store writes and frame requests
    always_comb begin
        wr_en   = take_data;
        wr_addr = load_idx_reg;
        wr_data = data_byte;
        q_push  = (take_data && store_full) || resend;
        q_pnum  = pnum_reg;
        node_id = node_id_reg;
    end

    // Hold protocol state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_RECEIVE;
            pnum_reg        <= PNUM_FIRST;
            ack_seen_reg    <= 1'b0;
            beacon_seen_reg <= 1'b0;
            load_idx_reg    <= '0;
        end else begin
            mode_reg        <= mode_next;
            pnum_reg        <= pnum_next;
            ack_seen_reg    <= ack_seen_next;
            beacon_seen_reg <= beacon_seen_next;
            load_idx_reg    <= load_idx_next;
        end
    end

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg <= '0;
            dest_id_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NODE_ID: node_id_reg <= cfg_wdata;
                CFG_DEST_ID: dest_id_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/sawarq_cmd_fifo.sv =====
`include "stop_and_wait_arq_sender_macros.svh"

module sawarq_cmd_fifo
    import sawarq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  logic [7:0] push_data,
    input  logic       pop,
    output logic [7:0] pop_data,
    output logic       full,
    output logic       empty
);

    logic [7:0] slot_reg [CMD_QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_comb begin
        full     = count_reg == 2'(CMD_QUEUE_DEPTH);
        empty    = count_reg == 2'd0;
        pop_data = slot_reg[rd_ptr_reg];
    end

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    `SAW_NEVER(a_no_overflow, push && full && !pop, "command pushed into full queue")
    `SAW_NEVER(a_no_underflow, pop && empty, "command popped from empty queue")

endmodule

// ===== hdl/sawarq_back.sv =====
`include "stop_and_wait_arq_sender_macros.svh"

module sawarq_back
    import sawarq_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    // packet store write from the front
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [7:0]    node_id,
    // frame command queue
    input  logic          q_empty,
    input  logic [7:0]    q_pnum,
    output logic          q_pop,
    output logic          busy,
    // frame byte stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    frame_byte,
    output logic          frame_last
);

    localparam int FRAME_LEN = PACKET_BYTES + HDR_BYTES;
    localparam int CW        = $clog2(FRAME_LEN);
    localparam int IW        = CW + 1;

    logic [7:0]    store [PACKET_BYTES];
    logic [7:0]    rd_data_reg;

    back_state_t   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    pnum_reg, pnum_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    logic          advance;
    logic          at_last;
    logic [IW-1:0] idx_next;
    logic [AW-1:0] rd_addr;
    logic [7:0]    cur_byte;

    // Pick the byte at the current frame position and the next store address
    always_comb begin
        advance  = (state_reg == BK_RUN) && (!m_valid_reg || m_tready);
        at_last  = cnt_reg == CW'(FRAME_LEN - 1);
        idx_next = advance ? {1'b0, cnt_reg} + IW'(1) : {1'b0, cnt_reg};
        if (idx_next >= IW'(HDR_BYTES) && idx_next < IW'(FRAME_LEN)) begin
            rd_addr = AW'(idx_next - IW'(HDR_BYTES));
        end else begin
            rd_addr = '0;
        end
        if (cnt_reg < CW'(ID_COPIES)) begin
            cur_byte = node_id;
        end else if (cnt_reg < CW'(HDR_BYTES)) begin
            cur_byte = pnum_reg;
        end else begin
            cur_byte = rd_data_reg;
        end
    end

    // Next state of the frame sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pnum_next    = pnum_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = BK_RUN;
                    cnt_next   = '0;
                    pnum_next  = q_pnum;
                end
            end
            BK_RUN: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    m_data_next  = cur_byte;
                    m_last_next  = at_last;
                    cnt_next     = cnt_reg + CW'(1);
                    if (at_last) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Drive queue and stream outputs
    always_comb begin
        q_pop      = (state_reg == BK_IDLE) && !q_empty;
        busy       = state_reg == BK_RUN;
        m_tvalid   = m_valid_reg;
        frame_byte = m_data_reg;
        frame_last = m_last_reg;
    end

    // Packet store with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= wr_data;
        end
        rd_data_reg <= store[rd_addr];
    end

    // Hold sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg    <= cnt_next;
        pnum_reg   <= pnum_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    `SAW_NEVER(a_no_write_in_frame, wr_en && (state_reg == BK_RUN), "store written during frame")
    `SAW_ASSERT(a_last_marked, advance && at_last |=> m_valid_reg && m_last_reg, "frame end lost")
    `SAW_ASSERT(a_hold_stalled, m_valid_reg && !m_tready |=> m_valid_reg, "stalled byte dropped")

endmodule

// ===== hdl/stop_and_wait_arq_sender.sv =====
// Stop-and-wait ARQ sender.
// Input channel s_*: one item per transfer. s_tuser selects the kind: an ack
// burst (destination and number copies) or one payload byte in s_tdata[55:48].
// Acks are taken in receive mode, payload bytes in load mode; items of the
// other kind are accepted and dropped. Configuration writes (source id, dest
// id) go through cfg_wr_en/cfg_index/cfg_wdata; the user must make them only
// while idle, as the block does not enforce it. Output channel m_*: one frame
// byte per transfer, three source ids, three packet numbers, then PACKET_BYTES
// payload bytes, m_tlast on the final one. Payload bytes load at one per cycle
// while s_tready is high. The byte that fills the store, or an ack that asks
// for a retransmit, queues a frame request; it passes through the queue and
// the sequencer state into the output register, and the frame then streams at
// one byte per cycle while m_tready is high; a frame waiting in the queue
// starts once the sequencer is back in idle. While a frame is queued or
// streaming, payload bytes are held off; acks are still taken until the
// two-entry request queue is full. A stall on m_tready holds the current byte
// and pauses the frame. Reset returns to receive mode with packet number 1,
// clears the request queue and output valid flag; the payload store is not cleared.
module stop_and_wait_arq_sender
    import sawarq_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // ack_dest_0, ack_dest_1, ack_dest_2, ack_num_0, ack_num_1, ack_num_2, data_byte
    input  logic [55:0]            s_tdata,
    // req_type
    input  logic                   s_tuser,
    // frame stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // frame_byte
    output logic [7:0]             m_tdata,
    // frame_last
    output logic                   m_tlast
);

    localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    logic [7:0]    q_push_pnum;
    logic [7:0]    q_pop_pnum;
    logic          back_busy;
    logic          store_busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    node_id;

    // Store is in use while a frame is queued or streaming
    assign store_busy = !q_empty || back_busy;

    sawarq_front #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req_type   (s_tuser),
        .ack_dest_0 (s_tdata[7:0]),
        .ack_dest_1 (s_tdata[15:8]),
        .ack_dest_2 (s_tdata[23:16]),
        .ack_num_0  (s_tdata[31:24]),
        .ack_num_1  (s_tdata[39:32]),
        .ack_num_2  (s_tdata[47:40]),
        .data_byte  (s_tdata[55:48]),
        .q_full     (q_full),
        .store_busy (store_busy),
        .q_push     (q_push),
        .q_pnum     (q_push_pnum),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .node_id    (node_id)
    );

    sawarq_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_pnum),
        .pop       (q_pop),
        .pop_data  (q_pop_pnum),
        .full      (q_full),
        .empty     (q_empty)
    );

    sawarq_back #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .node_id    (node_id),
        .q_empty    (q_empty),
        .q_pnum     (q_pop_pnum),
        .q_pop      (q_pop),
        .busy       (back_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .frame_byte (m_tdata),
        .frame_last (m_tlast)
    );

endmodule
